/* design/scb_pkg.sv */
// Shared types and constants for the serial command bridge.
package scb_pkg;

  // Input item kinds carried on the input tuser bit.
  localparam logic FUNC_RX   = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result destinations carried on the output tuser bits.
  localparam logic [1:0] DEST_SERIAL = 2'd0;
  localparam logic [1:0] DEST_SPI    = 2'd1;
  localparam logic [1:0] DEST_CLEAR  = 2'd2;

  // Command bytes received on the serial link.
  localparam logic [7:0] CMD_PAN     = 8'h10;
  localparam logic [7:0] CMD_TILT    = 8'h11;
  localparam logic [7:0] CMD_ENC_ON  = 8'h01;
  localparam logic [7:0] CMD_ENC_OFF = 8'h02;
  localparam logic [7:0] CMD_PING    = 8'hF0;

  // Response bytes and SPI register addresses.
  localparam logic [7:0] RESP_PING    = 8'hF1;
  localparam logic [7:0] RESP_PAN     = 8'h20;
  localparam logic [7:0] RESP_TILT    = 8'h21;
  localparam logic [7:0] SPI_PAN_REG  = 8'h01;
  localparam logic [7:0] SPI_TILT_REG = 8'h02;

  // Report period after reset, in ticks.
  localparam logic [15:0] REPORT_PERIOD_RST = 16'd100;

  // Longest burst of result bytes caused by one request.
  localparam int unsigned MAX_BEATS = 6;
  localparam int unsigned BEAT_W    = $clog2(MAX_BEATS + 1);

  // One burst of result bytes, all to the same destination; byte 0 goes first.
  typedef struct packed {
    logic [BEAT_W-1:0]           count;
    logic [1:0]                  dest;
    logic [MAX_BEATS-1:0][7:0]   bytes;
  } burst_t;

endpackage

/* design/scb_decode.sv */
// Command parser, report timer and period register: turns an accepted request into at most one burst.
module scb_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                accept,
  input  logic                func,
  input  logic [7:0]          rx_byte,
  input  logic signed [15:0]  pan_position,
  input  logic signed [15:0]  tilt_position,
  output scb_pkg::burst_t     desc,
  output logic                desc_valid
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PAN  = 2'd1,
    MODE_TILT = 2'd2
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic        reporting_r, reporting_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic [15:0] period_r;

  // Decode the accepted request against the parser and timer state.
  always_comb begin
    mode_nxt      = mode_r;
    reporting_nxt = reporting_r;
    countdown_nxt = countdown_r;
    desc          = '0;
    desc_valid    = 1'b0;
    if (accept) begin
      if (func == scb_pkg::FUNC_RX) begin
        case (mode_r)
          MODE_IDLE: begin
            if (rx_byte == scb_pkg::CMD_PAN) begin
              mode_nxt = MODE_PAN;
            end else if (rx_byte == scb_pkg::CMD_TILT) begin
              mode_nxt = MODE_TILT;
            end else if (rx_byte == scb_pkg::CMD_ENC_ON) begin
              reporting_nxt  = 1'b1;
              desc_valid     = 1'b1;
              desc.count     = scb_pkg::BEAT_W'(1);
              desc.dest      = scb_pkg::DEST_CLEAR;
            end else if (rx_byte == scb_pkg::CMD_ENC_OFF) begin
              reporting_nxt = 1'b0;
            end else if (rx_byte == scb_pkg::CMD_PING) begin
              desc_valid    = 1'b1;
              desc.count    = scb_pkg::BEAT_W'(1);
              desc.dest     = scb_pkg::DEST_SERIAL;
              desc.bytes[0] = scb_pkg::RESP_PING;
            end
          end
          MODE_PAN: begin
            desc_valid    = 1'b1;
            desc.count    = scb_pkg::BEAT_W'(2);
            desc.dest     = scb_pkg::DEST_SPI;
            desc.bytes[0] = scb_pkg::SPI_PAN_REG;
            desc.bytes[1] = rx_byte;
            mode_nxt      = MODE_IDLE;
          end
          MODE_TILT: begin
            desc_valid    = 1'b1;
            desc.count    = scb_pkg::BEAT_W'(2);
            desc.dest     = scb_pkg::DEST_SPI;
            desc.bytes[0] = scb_pkg::SPI_TILT_REG;
            desc.bytes[1] = rx_byte;
            mode_nxt      = MODE_IDLE;
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end else if (reporting_r) begin
        // A countdown of one or zero fires, reloading from the period.
        if (countdown_r <= 16'd1) begin
          countdown_nxt = period_r;
          desc_valid    = 1'b1;
          desc.count    = scb_pkg::BEAT_W'(scb_pkg::MAX_BEATS);
          desc.dest     = scb_pkg::DEST_SERIAL;
          desc.bytes[0] = scb_pkg::RESP_PAN;
          desc.bytes[1] = pan_position[7:0];
          desc.bytes[2] = pan_position[15:8];
          desc.bytes[3] = scb_pkg::RESP_TILT;
          desc.bytes[4] = tilt_position[7:0];
          desc.bytes[5] = tilt_position[15:8];
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end
    end
  end

  // Parser state, timer and period register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      reporting_r <= 1'b0;
      countdown_r <= scb_pkg::REPORT_PERIOD_RST;
      period_r    <= scb_pkg::REPORT_PERIOD_RST;
    end else begin
      mode_r      <= mode_nxt;
      reporting_r <= reporting_nxt;
      countdown_r <= countdown_nxt;
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
    end
  end

endmodule

/* design/scb_burst.sv */
// Burst holding register and byte serializer feeding the registered result port.
module scb_burst (
  input  logic             clk,
  input  logic             rst_n,
  input  scb_pkg::burst_t  desc,
  input  logic             desc_valid,
  output logic             pend_free,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  scb_pkg::burst_t                     pend_r;
  logic                                pend_valid_r;
  logic [scb_pkg::MAX_BEATS-1:0][7:0]  cur_bytes_r;
  logic [1:0]                          cur_dest_r;
  logic [scb_pkg::BEAT_W-1:0]          rem_r;
  logic                                out_valid_r;
  logic [7:0]                          out_byte_r;
  logic [1:0]                          out_dest_r;
  logic                                out_last_r;
  logic                                adv;
  logic                                pend_take;

  // The output register can load a new beat when empty or being drained.
  assign adv       = !out_valid_r || out_tready;
  assign pend_take = adv && (rem_r == '0) && pend_valid_r;
  // The holding register can take a new burst when empty or handing its burst on.
  assign pend_free = !pend_valid_r || pend_take;

  // Holding register for one decoded burst.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (desc_valid) begin
      pend_valid_r <= 1'b1;
    end else if (pend_take) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid) begin
      pend_r <= desc;
    end
  end

  // Serializer: first beat from the holding register, the rest shifted out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else if (adv) begin
      if (rem_r != '0) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= cur_bytes_r[0];
        out_dest_r  <= cur_dest_r;
        out_last_r  <= (rem_r == scb_pkg::BEAT_W'(1));
        cur_bytes_r <= {8'h00, cur_bytes_r[scb_pkg::MAX_BEATS-1:1]};
        rem_r       <= rem_r - scb_pkg::BEAT_W'(1);
      end else if (pend_valid_r) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= pend_r.bytes[0];
        out_dest_r  <= pend_r.dest;
        out_last_r  <= (pend_r.count == scb_pkg::BEAT_W'(1));
        cur_bytes_r <= {8'h00, pend_r.bytes[scb_pkg::MAX_BEATS-1:1]};
        cur_dest_r  <= pend_r.dest;
        rem_r       <= pend_r.count - scb_pkg::BEAT_W'(1);
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_dest_r;
  assign out_tlast  = out_last_r;

endmodule

/* design/serial_command_bridge_with_telemetry.sv */
// Top level of the serial command bridge with periodic encoder reports.
// The first result of a request passes through the burst holding register and then the output register.
// Throughput: a request is taken every cycle while the burst holding register is free
// or is handing its burst to the serializer; the result port sends one byte a cycle while
// out_tready is high, and a report burst is six bytes long.
// One decoded burst can wait while the result port is stalled, so input is held off
// only when both the holding register and the serializer are busy.
// Reset (synchronous, active low): reports off, parser idle, period and countdown 100.
module serial_command_bridge_with_telemetry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // report_period
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // rx_byte [7:0], pan_position [23:8], tilt_position [39:24]
  input  logic        in_tuser,    // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // out_byte [7:0]
  output logic [1:0]  out_tuser,   // dest [1:0]
  output logic        out_tlast    // last
);

  scb_pkg::burst_t desc;
  logic            desc_valid;
  logic            accept;

  assign accept = in_tvalid && in_tready;

  // Parse the request and update the parser and report timer.
  scb_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .func          (in_tuser),
    .rx_byte       (in_tdata[7:0]),
    .pan_position  (in_tdata[23:8]),
    .tilt_position (in_tdata[39:24]),
    .desc          (desc),
    .desc_valid    (desc_valid)
  );

  // Hold the burst and send it out one byte at a time.
  scb_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (desc),
    .desc_valid (desc_valid),
    .pend_free  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A decoded burst always has one to six bytes, and SPI bursts exactly two.
  a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid |-> (desc.count != '0) &&
                   (desc.count <= scb_pkg::BEAT_W'(scb_pkg::MAX_BEATS)) &&
                   ((desc.dest != scb_pkg::DEST_SPI) || (desc.count == scb_pkg::BEAT_W'(2))))
    else $error("decoded burst has a bad length");

  // A burst is only produced for an accepted request.
  a_burst_accept: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid |-> accept)
    else $error("burst produced without an accepted request");

  // An encoder clear pulse is a single zero byte that ends its burst.
  a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == scb_pkg::DEST_CLEAR) |-> out_tlast && (out_tdata == 8'h00))
    else $error("encoder clear pulse malformed");

  // No result carries the unused destination code.
  a_dest_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == scb_pkg::DEST_SERIAL) || (out_tuser == scb_pkg::DEST_SPI) ||
                   (out_tuser == scb_pkg::DEST_CLEAR))
    else $error("result has an unused destination code");

endmodule
